>>> src/multi_stream_prime_modulus_lcg_unit_macros.svh
// Assertion macros shared by the checker of the multi-stream generator
`ifndef MULTI_STREAM_PRIME_MODULUS_LCG_UNIT_MACROS_SVH
`define MULTI_STREAM_PRIME_MODULUS_LCG_UNIT_MACROS_SVH

// Check a property on every clock edge, outside reset
`define MSLCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define MSLCG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/mslcg_pkg.sv
// Package: types, constants and seed table of the multi-stream generator
package mslcg_pkg;

    localparam int NUM_STREAMS = 101;
    localparam int ADDR_W      = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int TABLE_LEN   = 101;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] MODULUS = 32'h7FFF_FFFF;
    localparam logic [14:0] MULT_A  = 15'd24112;
    localparam logic [14:0] MULT_B  = 15'd26143;

    // Command codes on the input port
    localparam logic [1:0] CMD_NEXT = 2'd0;
    localparam logic [1:0] CMD_SEED = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_SEED,
        OP_READ,
        OP_ERR
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_PUT
    } t_bstate;

    typedef struct packed {
        t_op         op;
        logic [6:0]  idx;
        logic [30:0] seed;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [30:0] x;
        logic [14:0] mult;
    } t_mm_req;

    typedef struct packed {
        logic        valid;
        logic [30:0] res;
    } t_mm_rsp;

    localparam logic [30:0] SEED_TAB [0:TABLE_LEN-1] = '{
        31'd1,
        31'd1973272912, 31'd281629770,  31'd20006270,   31'd1280689831, 31'd2096730329,
        31'd1933576050, 31'd913566091,  31'd246780520,  31'd1363774876, 31'd604901985,
        31'd1511192140, 31'd1259851944, 31'd824064364,  31'd150493284,  31'd242708531,
        31'd75253171,   31'd1964472944, 31'd1202299975, 31'd233217322,  31'd1911216000,
        31'd726370533,  31'd403498145,  31'd993232223,  31'd1103205531, 31'd762430696,
        31'd1922803170, 31'd1385516923, 31'd76271663,   31'd413682397,  31'd726466604,
        31'd336157058,  31'd1432650381, 31'd1120463904, 31'd595778810,  31'd877722890,
        31'd1046574445, 31'd68911991,   31'd2088367019, 31'd748545416,  31'd622401386,
        31'd2122378830, 31'd640690903,  31'd1774806513, 31'd2132545692, 31'd2079249579,
        31'd78130110,   31'd852776735,  31'd1187867272, 31'd1351423507, 31'd1645973084,
        31'd1997049139, 31'd922510944,  31'd2045512870, 31'd898585771,  31'd243649545,
        31'd1004818771, 31'd773686062,  31'd403188473,  31'd372279877,  31'd1901633463,
        31'd498067494,  31'd2087759558, 31'd493157915,  31'd597104727,  31'd1530940798,
        31'd1814496276, 31'd536444882,  31'd1663153658, 31'd855503735,  31'd67784357,
        31'd1432404475, 31'd619691088,  31'd119025595,  31'd880802310,  31'd176192644,
        31'd1116780070, 31'd277854671,  31'd1366580350, 31'd1142483975, 31'd2026948561,
        31'd1053920743, 31'd786262391,  31'd1792203830, 31'd1494667770, 31'd1923011392,
        31'd1433700034, 31'd1244184613, 31'd1147297105, 31'd539712780,  31'd1545929719,
        31'd190641742,  31'd1645390429, 31'd264907697,  31'd620389253,  31'd1502074852,
        31'd927711160,  31'd364849192,  31'd2049576050, 31'd638580085,  31'd547070247
    };

    // Power-up state of a stream; streams past the published table start at one
    function automatic logic [30:0] seed_reset(input logic [6:0] idx);
        logic [30:0] v;
        v = 31'd1;
        if ({1'b0, idx} < 8'(TABLE_LEN)) begin
            v = SEED_TAB[idx];
        end
        return v;
    endfunction

endpackage

>>> src/mslcg_front.sv
// Front end: accept commands and classify them into internal operations
module mslcg_front import mslcg_pkg::*; (
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_stream_index,
    input  logic [30:0] i_seed_value,
    output logic        o_wr,
    output t_item       o_item
);

    // Pass a transfer to the queue
    assign o_wr = i_push && !i_full;

    // Reject out-of-range streams, fold the unused code into a read
    always_comb begin
        o_item.idx  = i_stream_index;
        o_item.seed = i_seed_value;
        if ({1'b0, i_stream_index} >= 8'(NUM_STREAMS)) begin
            o_item.op = OP_ERR;
        end else begin
            case (i_cmd)
                CMD_NEXT: o_item.op = OP_NEXT;
                CMD_SEED: o_item.op = OP_SEED;
                CMD_READ: o_item.op = OP_READ;
                default:  o_item.op = OP_READ;
            endcase
        end
    end

endmodule

>>> src/mslcg_queue.sv
// Short queue that decouples the front end from the back end
module mslcg_queue import mslcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

>>> src/mslcg_mulmod.sv
// Three-stage multiply by a 15-bit constant modulo 2^31-1, split-word reduction
module mslcg_mulmod import mslcg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    logic [2:0]  r_v;
    logic [30:0] r_lo_p;
    logic [29:0] r_hi_p;
    logic [30:0] r_high;
    logic [15:0] r_lo16;
    logic [30:0] r_res;

    logic [30:0] w_lo_p;
    logic [29:0] w_hi_p;
    logic [31:0] w_sum;
    logic [31:0] w_red;

    // Partial products of the low 16 and high 15 bits
    assign w_lo_p = {15'b0, i_req.x[15:0]} * {16'b0, i_req.mult};
    assign w_hi_p = {15'b0, i_req.x[30:16]} * {15'b0, i_req.mult};

    // Fold the high word back in and take one modulus off if needed
    assign w_sum = {1'b0, r_high[14:0], r_lo16} + {16'b0, r_high[30:15]};
    assign w_red = (w_sum >= MODULUS) ? (w_sum - MODULUS) : w_sum;

    // Track the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_req.start};
        end
    end

    // Pipeline data
    always_ff @(posedge i_clk) begin
        r_lo_p <= w_lo_p;
        r_hi_p <= w_hi_p;
        r_high <= {1'b0, r_hi_p} + {16'b0, r_lo_p[30:16]};
        r_lo16 <= r_lo_p[15:0];
        r_res  <= w_red[30:0];
    end

    assign o_rsp.valid = r_v[2];
    assign o_rsp.res   = r_res;

endmodule

>>> src/mslcg_back.sv
// Back end: stream state memory, command sequencer and result register
module mslcg_back import mslcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_q_rd,
    output t_mm_req     o_mm_req,
    input  t_mm_rsp     i_mm_rsp,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [30:0] o_state_value,
    output logic [23:0] o_fraction,
    output logic        o_status
);

    logic [30:0]            r_mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0] r_vld;

    t_bstate     r_state, n_state;
    t_op         r_op, n_op;
    logic [6:0]  r_idx, n_idx;
    logic [30:0] r_seed, n_seed;
    logic        r_pass, n_pass;
    logic [30:0] r_res, n_res;
    logic        r_out_vld, n_out_vld;
    logic [30:0] r_out_state, n_out_state;
    logic [23:0] r_out_frac, n_out_frac;
    logic        r_out_status, n_out_status;

    logic [30:0] r_rd_data;
    logic        r_rd_hit;
    logic [30:0] r_rd_tab;
    logic [30:0] w_x;
    logic        w_we;

    // Unwritten streams read as their power-up seed
    assign w_x = r_rd_hit ? r_rd_data : r_rd_tab;

    // Sequence one command at a time
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_seed       = r_seed;
        n_pass       = r_pass;
        n_res        = r_res;
        n_out_vld    = r_out_vld && !i_pop;
        n_out_state  = r_out_state;
        n_out_frac   = r_out_frac;
        n_out_status = r_out_status;
        o_q_rd       = 1'b0;
        o_mm_req     = '0;
        w_we         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd  = 1'b1;
                    n_op    = i_q_item.op;
                    n_idx   = i_q_item.idx;
                    n_seed  = i_q_item.seed;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_PUT;
                case (r_op)
                    OP_NEXT: begin
                        o_mm_req.start = 1'b1;
                        o_mm_req.x     = w_x;
                        o_mm_req.mult  = MULT_A;
                        n_pass         = 1'b0;
                        n_state        = S_MUL;
                    end
                    OP_SEED: n_res = r_seed;
                    OP_READ: n_res = w_x;
                    default: n_res = '0;
                endcase
            end
            S_MUL: begin
                if (i_mm_rsp.valid) begin
                    if (!r_pass) begin
                        o_mm_req.start = 1'b1;
                        o_mm_req.x     = i_mm_rsp.res;
                        o_mm_req.mult  = MULT_B;
                        n_pass         = 1'b1;
                    end else begin
                        n_res   = i_mm_rsp.res;
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                if (!r_out_vld || i_pop) begin
                    n_out_vld    = 1'b1;
                    n_out_state  = r_res;
                    n_out_frac   = (r_op == OP_NEXT) ? {r_res[30:8], 1'b1} : '0;
                    n_out_status = (r_op == OP_ERR);
                    w_we         = (r_op == OP_NEXT) || (r_op == OP_SEED);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Hold command and result payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_seed       <= n_seed;
        r_pass       <= n_pass;
        r_res        <= n_res;
        r_out_state  <= n_out_state;
        r_out_frac   <= n_out_frac;
        r_out_status <= n_out_status;
    end

    // Mark streams that have been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[r_idx[ADDR_W-1:0]] <= 1'b1;
        end
    end

    // Read the stream state when a command leaves the queue
    always_ff @(posedge i_clk) begin
        if (o_q_rd && (i_q_item.op != OP_ERR)) begin
            r_rd_data <= r_mem[i_q_item.idx[ADDR_W-1:0]];
            r_rd_hit  <= r_vld[i_q_item.idx[ADDR_W-1:0]];
            r_rd_tab  <= seed_reset(i_q_item.idx);
        end
    end

    // Write back the new state
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx[ADDR_W-1:0]] <= r_res;
        end
    end

    assign o_empty       = !r_out_vld;
    assign o_state_value = r_out_state;
    assign o_fraction    = r_out_frac;
    assign o_status      = r_out_status;

endmodule

>>> src/multi_stream_prime_modulus_lcg_unit.sv
// Top level: multi-stream prime-modulus generator, front end, queue and back end
// The unit keeps 101 generator streams, each reset to its published seed, and
// answers one result per command in command order. An advance command in the
// back end takes a state read, two passes through the shared three-stage
// modular multiplier (24112, then 26143) and a write-back of the new state.
// Seed, read and out-of-range commands skip the multiplier. A two-entry queue in
// front lets commands be pushed while earlier ones are still in work, and the
// result register lets a finished result wait for pop while the next command
// starts. No clearing pass follows reset: the unit accepts commands at once.
module multi_stream_prime_modulus_lcg_unit import mslcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_stream_index,
    input  logic [30:0] i_seed_value,
    output logic        empty,
    input  logic        pop,
    output logic [30:0] o_state_value,
    output logic [23:0] o_fraction,
    output logic        o_status
);

    logic    w_wr;
    t_item   w_in_item;
    logic    w_q_empty;
    t_item   w_q_item;
    logic    w_q_rd;
    t_mm_req w_mm_req;
    t_mm_rsp w_mm_rsp;

    mslcg_front u_front (
        .i_push         (push),
        .i_full         (full),
        .i_cmd          (i_cmd),
        .i_stream_index (i_stream_index),
        .i_seed_value   (i_seed_value),
        .o_wr           (w_wr),
        .o_item         (w_in_item)
    );

    mslcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_item  (w_in_item),
        .o_full  (full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    mslcg_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mm_req),
        .o_rsp   (w_mm_rsp)
    );

    mslcg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_q_item),
        .o_q_rd        (w_q_rd),
        .o_mm_req      (w_mm_req),
        .i_mm_rsp      (w_mm_rsp),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_state_value (o_state_value),
        .o_fraction    (o_fraction),
        .o_status      (o_status)
    );

endmodule

>>> src/mslcg_checker.sv
// Port-level checker for the multi-stream generator, bound to the top level
`include "multi_stream_prime_modulus_lcg_unit_macros.svh"

module mslcg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [1:0]  i_cmd,
    input logic [6:0]  i_stream_index,
    input logic [30:0] i_seed_value,
    input logic        empty,
    input logic        pop,
    input logic [30:0] o_state_value,
    input logic [23:0] o_fraction,
    input logic        o_status
);

    // No result is shown right after reset
    `MSLCG_ASSERT_ALWAYS(a_empty_after_reset, (!i_rst_n |=> empty), "result shown after reset")

    // Error results carry no state and no fraction
    `MSLCG_ASSERT(a_err_zero, (!empty && o_status |-> o_state_value == 31'd0 && o_fraction == 24'd0), "error result not zero")

    // A nonzero fraction is the state's top bits with the low bit set
    `MSLCG_ASSERT(a_frac_form, (!empty && o_fraction != 24'd0 |-> o_fraction[0] && o_fraction[23:1] == o_state_value[30:8] && !o_status), "fraction does not match state")

    // A waiting result holds until its transfer
    `MSLCG_ASSERT(a_out_hold, (!empty && !pop |=> !empty && $stable(o_state_value) && $stable(o_fraction) && $stable(o_status)), "waiting result changed")

endmodule

bind multi_stream_prime_modulus_lcg_unit mslcg_checker u_checker (.*);
